// ===== rtl/core/owubfc_pkg.sv =====
// ----------------------------------------------------------------------------
// One-wire UART boot frame checker package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package owubfc_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 248;
   localparam int INFO_BYTES_DEF      = 9;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 32;
   localparam int QUEUE_DEPTH         = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIT_PERIOD   = 3'd0,
      CSR_FIRST_OFFSET = 3'd1,
      CSR_WAIT_LIMIT   = 3'd2,
      CSR_MARKER       = 3'd3,
      CSR_INIT_LEN     = 3'd4,
      CSR_INFO_ZERO    = 3'd5,
      CSR_INFO_ONE     = 3'd6,
      CSR_INFO_LAST    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_RECV = 2'd1,
      PH_SEND = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      VERDICT_SHORT = 2'd0,
      VERDICT_GOOD  = 2'd1,
      VERDICT_BAD   = 2'd2,
      VERDICT_INIT  = 2'd3
   } verdict_type;

   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [9:0]  bit_period;
      logic [9:0]  first_offset;
      logic [15:0] wait_limit;
      logic [7:0]  marker;
      logic [7:0]  init_len;
      logic [31:0] info_zero;
      logic [31:0] info_one;
      logic [7:0]  info_last;
   } cfg_type;

   typedef struct packed {
      logic       line_level;
   } tick_type;

   typedef struct packed {
      logic       line_out;
      logic       line_drive;
      logic       byte_valid;
      logic [7:0] byte_value;
      logic       frame_done;
      logic [7:0] frame_length;
      logic [1:0] frame_verdict;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/owubfc_front.sv =====
// ----------------------------------------------------------------------------
// Tick intake
// Accepts line samples and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module owubfc_front
   import owubfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  tick_type req_tick,
   output logic     q_valid,
   input  logic     q_ready,
   output tick_type q_tick
);

   tick_type   mem_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != 2'd0);
   assign q_tick    = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_tick;
      end
   end

endmodule

// ===== rtl/core/owubfc_engine.sv =====
// ----------------------------------------------------------------------------
// Receive and reply engine
// Runs the 8N1 receiver, frame CRC check and reply transmitter, one tick
// per cycle unless its two-entry result register toward the output is full.
// ----------------------------------------------------------------------------
module owubfc_engine
   import owubfc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
   parameter int INFO_BYTES      = INFO_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   output logic       q_ready,
   input  tick_type   q_tick,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

   phase_type         phase_ff, phase_in;
   logic [15:0]       tick_ff, tick_in;
   logic [3:0]        bit_ff, bit_in;
   logic [9:0]        rx_ff, rx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        pend0_ff, pend0_in, pend1_ff, pend1_in;
   logic [3:0]        txi_ff, txi_in;
   logic [9:0]        txs_ff, txs_in;

   result_type        res;
   result_type        ob_ff [2];
   logic [1:0]        ob_cnt_ff, ob_cnt_in;
   logic              ob_wr_ff, ob_rd_ff;
   logic              step, pop;

   logic [15:0]       per, limit;
   logic [9:0]        rx_new;
   logic [7:0]        rx_byte;
   logic              frame_end;
   logic [CNT_W-1:0]  end_count;
   logic [7:0]        end_last;
   logic [15:0]       end_crc;
   logic [7:0]        end_prev;

   function automatic logic [7:0] info_byte(input logic [3:0] i, input cfg_type c);
      logic [7:0] b;
      case (i)
         4'd0:    b = c.info_zero[7:0];
         4'd1:    b = c.info_zero[15:8];
         4'd2:    b = c.info_zero[23:16];
         4'd3:    b = c.info_zero[31:24];
         4'd4:    b = c.info_one[7:0];
         4'd5:    b = c.info_one[15:8];
         4'd6:    b = c.info_one[23:16];
         4'd7:    b = c.info_one[31:24];
         default: b = c.info_last;
      endcase
      return b;
   endfunction

   assign q_ready = (ob_cnt_ff != 2'd2);
   assign step    = q_valid && q_ready;
   assign rsp_valid  = (ob_cnt_ff != 2'd0);
   assign rsp_result = ob_ff[ob_rd_ff];
   assign pop        = rsp_valid && rsp_ready;

   assign per   = (cfg.bit_period == 10'd0) ? 16'd1 : {6'd0, cfg.bit_period};
   assign limit = (cfg.wait_limit == 16'd0) ? 16'd1 : cfg.wait_limit;
   assign rx_new  = rx_ff | (q_tick.line_level ? (10'd1 << bit_ff) : 10'd0);
   assign rx_byte = rx_new[8:1];

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      rx_in    = rx_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      txi_in   = txi_ff;
      txs_in   = txs_ff;
      res      = '0;
      res.line_out = 1'b1;
      frame_end = 1'b0;
      end_count = count_ff;
      end_last  = pend1_ff;
      end_prev  = pend0_ff;
      end_crc   = crc_ff;

      unique case (phase_ff)
         PH_SEND: begin
            res.line_out   = txs_ff[0];
            res.line_drive = 1'b1;
            tick_in = tick_ff + 16'd1;
            if (tick_in >= per) begin
               tick_in = 16'd0;
               txs_in  = {1'b1, txs_ff[9:1]};
               bit_in  = bit_ff + 4'd1;
               if (bit_in >= 4'd10) begin
                  bit_in = 4'd0;
                  txi_in = txi_ff + 4'd1;
                  if (txi_in >= 4'(INFO_BYTES)) begin
                     txi_in   = 4'd0;
                     txs_in   = 10'h3FF;
                     phase_in = PH_WAIT;
                     count_in = '0;
                     crc_in   = 16'd0;
                     pend0_in = 8'd0;
                     pend1_in = 8'd0;
                  end else begin
                     txs_in = {1'b1, info_byte(txi_in, cfg), 1'b0};
                  end
               end
            end
         end
         PH_RECV: begin
            if (tick_ff != 16'd0) begin
               tick_in = tick_ff - 16'd1;
            end else begin
               rx_in  = rx_new;
               bit_in = bit_ff + 4'd1;
               if (bit_in < 4'd10) begin
                  tick_in = per - 16'd1;
               end else begin
                  bit_in   = 4'd0;
                  tick_in  = 16'd0;
                  phase_in = PH_WAIT;
                  if (rx_new[0] || !rx_new[9]) begin
                     frame_end = 1'b1;
                  end else begin
                     res.byte_valid = 1'b1;
                     res.byte_value = rx_byte;
                     if (count_ff >= CNT_W'(2)) crc_in = crc_byte(crc_ff, pend0_ff);
                     pend0_in = pend1_ff;
                     pend1_in = rx_byte;
                     count_in = count_ff + CNT_W'(1);
                     end_count = count_in;
                     end_last  = rx_byte;
                     end_prev  = pend1_ff;
                     end_crc   = crc_in;
                     if (count_in >= CNT_W'(MAX_FRAME_BYTES)) frame_end = 1'b1;
                  end
               end
            end
         end
         default: begin
            if (!q_tick.line_level) begin
               rx_in    = 10'd0;
               phase_in = PH_RECV;
               if (cfg.first_offset == 10'd0) begin
                  bit_in  = 4'd1;
                  tick_in = per - 16'd1;
               end else begin
                  bit_in  = 4'd0;
                  tick_in = {6'd0, cfg.first_offset} - 16'd1;
               end
            end else begin
               tick_in = tick_ff + 16'd1;
               if (tick_in >= limit) begin
                  tick_in   = 16'd0;
                  frame_end = 1'b1;
               end
            end
         end
      endcase

      if (frame_end) begin
         if (end_count != '0) begin
            res.frame_done   = 1'b1;
            res.frame_length = 8'(end_count);
            if (16'(end_count) == {8'd0, cfg.init_len} && end_last == cfg.marker) begin
               res.frame_verdict = VERDICT_INIT;
            end else if (end_count >= CNT_W'(3)) begin
               res.frame_verdict = ({end_last, end_prev} == end_crc) ? VERDICT_GOOD
                                                                     : VERDICT_BAD;
            end else begin
               res.frame_verdict = VERDICT_SHORT;
            end
         end
         count_in = '0;
         crc_in   = 16'd0;
         pend0_in = 8'd0;
         pend1_in = 8'd0;
         tick_in  = 16'd0;
         bit_in   = 4'd0;
         phase_in = PH_WAIT;
         if (res.frame_verdict == VERDICT_INIT && res.frame_done) begin
            phase_in = PH_SEND;
            txi_in   = 4'd0;
            txs_in   = {1'b1, info_byte(4'd0, cfg), 1'b0};
         end
      end
   end

   always_comb begin
      ob_cnt_in = ob_cnt_ff + {1'b0, step} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         tick_ff   <= 16'd0;
         bit_ff    <= 4'd0;
         rx_ff     <= 10'd0;
         count_ff  <= '0;
         crc_ff    <= 16'd0;
         pend0_ff  <= 8'd0;
         pend1_ff  <= 8'd0;
         txi_ff    <= 4'd0;
         txs_ff    <= 10'h3FF;
         ob_cnt_ff <= 2'd0;
         ob_wr_ff  <= 1'b0;
         ob_rd_ff  <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            bit_ff   <= bit_in;
            rx_ff    <= rx_in;
            count_ff <= count_in;
            crc_ff   <= crc_in;
            pend0_ff <= pend0_in;
            pend1_ff <= pend1_in;
            txi_ff   <= txi_in;
            txs_ff   <= txs_in;
            ob_wr_ff <= ~ob_wr_ff;
         end
         if (pop) ob_rd_ff <= ~ob_rd_ff;
         ob_cnt_ff <= ob_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) ob_ff[ob_wr_ff] <= res;
   end

endmodule

// ===== rtl/core/one_wire_uart_boot_frame_checker_unit.sv =====
// An accepted tick is written into the intake queue; the engine steps it at
// the queue head when the result buffer has room, and registers its result
// word into it. Throughput: one tick per cycle unless that buffer is full.
// A two-word intake queue and a two-word result buffer decouple the sides.
// Reset is synchronous and active high; it restores all register defaults
// and returns the receiver to waiting for a start edge.
module one_wire_uart_boot_frame_checker_unit
   import owubfc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
   parameter int INFO_BYTES      = INFO_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_line_level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_line_out,
   output logic                   rsp_line_drive,
   output logic                   rsp_byte_valid,
   output logic [7:0]             rsp_byte_value,
   output logic                   rsp_frame_done,
   output logic [7:0]             rsp_frame_length,
   output logic [1:0]             rsp_frame_verdict
);

   cfg_type    cfg_ff;
   tick_type   req_tick, q_tick;
   logic       q_valid, q_ready;
   result_type res;

   assign csr_ready = 1'b1;
   assign req_tick.line_level = req_line_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period   <= 10'd52;
         cfg_ff.first_offset <= 10'd6;
         cfg_ff.wait_limit   <= 16'd2000;
         cfg_ff.marker       <= 8'h7D;
         cfg_ff.init_len     <= 8'd21;
         cfg_ff.info_zero    <= 32'h0031_3734;
         cfg_ff.info_one     <= 32'h0106_061F;
         cfg_ff.info_last    <= 8'h30;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIT_PERIOD:   cfg_ff.bit_period   <= csr_data[9:0];
            CSR_FIRST_OFFSET: cfg_ff.first_offset <= csr_data[9:0];
            CSR_WAIT_LIMIT:   cfg_ff.wait_limit   <= csr_data[15:0];
            CSR_MARKER:       cfg_ff.marker       <= csr_data[7:0];
            CSR_INIT_LEN:     cfg_ff.init_len     <= csr_data[7:0];
            CSR_INFO_ZERO:    cfg_ff.info_zero    <= csr_data;
            CSR_INFO_ONE:     cfg_ff.info_one     <= csr_data;
            default:          cfg_ff.info_last    <= csr_data[7:0];
         endcase
      end
   end

   owubfc_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_tick,
      .q_valid, .q_ready, .q_tick
   );

   owubfc_engine #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES), .INFO_BYTES(INFO_BYTES)
   ) u_engine (
      .clock, .reset, .cfg(cfg_ff), .q_valid, .q_ready, .q_tick,
      .rsp_valid, .rsp_ready, .rsp_result(res)
   );

   assign rsp_line_out      = res.line_out;
   assign rsp_line_drive    = res.line_drive;
   assign rsp_byte_valid    = res.byte_valid;
   assign rsp_byte_value    = res.byte_value;
   assign rsp_frame_done    = res.frame_done;
   assign rsp_frame_length  = res.frame_length;
   assign rsp_frame_verdict = res.frame_verdict;

endmodule

// ===== rtl/core/owubfc_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module owubfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_line_out,
   input logic       rsp_line_drive,
   input logic       rsp_byte_valid,
   input logic [7:0] rsp_byte_value,
   input logic       rsp_frame_done,
   input logic [1:0] rsp_frame_verdict
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_value))
      else $error("result word dropped or changed while stalled");

   a_idle_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_drive |-> rsp_line_out)
      else $error("line driven low while released");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_byte_value == 8'd0)
      else $error("byte value set without a valid byte");

   a_verdict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_frame_verdict == 2'd0)
      else $error("verdict set without frame end");

endmodule

bind one_wire_uart_boot_frame_checker_unit owubfc_checker u_owubfc_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_line_out, .rsp_line_drive,
   .rsp_byte_valid, .rsp_byte_value, .rsp_frame_done, .rsp_frame_verdict
);

// ===== sim/one_wire_uart_boot_frame_checker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-wire UART boot frame checker testbench
// Drives line samples one word per tick, builds 8N1 frames with and without a
// good trailing CRC, init frames and broken bytes, and checks every result
// word against a cycle-free model of the receiver and the reply transmitter.
// ----------------------------------------------------------------------------
module one_wire_uart_boot_frame_checker_unit_tb;
   import owubfc_pkg::*;

   localparam int WATCHDOG_LIMIT = 30000;
   localparam int FULL_FRAME     = 248;
   localparam int REPLY_BYTES    = 9;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_BIT_PERIOD;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_line_level = 1'b1;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_line_out;
   logic                   rsp_line_drive;
   logic                   rsp_byte_valid;
   logic [7:0]             rsp_byte_value;
   logic                   rsp_frame_done;
   logic [7:0]             rsp_frame_length;
   logic [1:0]             rsp_frame_verdict;

   one_wire_uart_boot_frame_checker_unit uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_line_level(req_line_level),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_line_out(rsp_line_out), .rsp_line_drive(rsp_line_drive),
      .rsp_byte_valid(rsp_byte_valid), .rsp_byte_value(rsp_byte_value),
      .rsp_frame_done(rsp_frame_done), .rsp_frame_length(rsp_frame_length),
      .rsp_frame_verdict(rsp_frame_verdict)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver model state and register copy.
   cfg_type     cfg;
   phase_type   ph;
   logic [15:0] tick_cnt;
   logic [3:0]  bit_idx;
   logic [9:0]  rx_bits;
   logic [15:0] byte_cnt;
   logic [15:0] crc_acc;
   logic [7:0]  older_byte;
   logic [7:0]  newest_byte;
   logic [3:0]  reply_idx;
   logic [9:0]  reply_bits;
   result_type  tick_res;

   result_type  line_results[$];
   int          errors = 0;
   int          ticks_sent = 0;
   int          send_idle = 0;
   int          recv_stall = 0;
   int          hold_seq = 0;
   int          hold_seen = 0;
   int          hold_cnt = 0;
   int          quiet_cycles = 0;

   function automatic logic [15:0] crc16_arc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'd0, b};
      for (int k = 0; k < 8; k++)
         r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      return r;
   endfunction

   function automatic logic [7:0] info_byte(int i);
      if (i < 4) return cfg.info_zero[8*i +: 8];
      if (i < 8) return cfg.info_one[8*(i-4) +: 8];
      return cfg.info_last;
   endfunction

   function automatic logic [15:0] period_ticks();
      return (cfg.bit_period == 0) ? 16'd1 : {6'd0, cfg.bit_period};
   endfunction

   function automatic void clear_rx();
      byte_cnt = 0;
      crc_acc = 0;
      older_byte = 0;
      newest_byte = 0;
      tick_cnt = 0;
      bit_idx = 0;
      ph = PH_WAIT;
   endfunction

   function automatic void close_frame();
      logic reply;
      reply = 1'b0;
      if (byte_cnt == 0) begin
         clear_rx();
         return;
      end
      tick_res.frame_done = 1'b1;
      tick_res.frame_length = byte_cnt[7:0];
      if (byte_cnt == {8'd0, cfg.init_len} && newest_byte == cfg.marker) begin
         tick_res.frame_verdict = VERDICT_INIT;
         reply = 1'b1;
      end else if (byte_cnt >= 3) begin
         // The last two bytes carry the CRC, low byte first.
         tick_res.frame_verdict = ({newest_byte, older_byte} == crc_acc) ?
                                  VERDICT_GOOD : VERDICT_BAD;
      end else begin
         tick_res.frame_verdict = VERDICT_SHORT;
      end
      clear_rx();
      if (reply) begin
         ph = PH_SEND;
         reply_idx = 0;
         reply_bits = {1'b1, info_byte(0), 1'b0};
      end
   endfunction

   function automatic void line_tick(logic lvl);
      logic [15:0] per;
      logic [15:0] lim;
      logic [7:0]  b;
      per = period_ticks();
      tick_res = '0;
      tick_res.line_out = 1'b1;
      case (ph)
         PH_SEND: begin
            tick_res.line_out = reply_bits[0];
            tick_res.line_drive = 1'b1;
            tick_cnt++;
            if (tick_cnt >= per) begin
               tick_cnt = 0;
               reply_bits = {1'b1, reply_bits[9:1]};
               bit_idx++;
               if (bit_idx >= 10) begin
                  bit_idx = 0;
                  reply_idx++;
                  if (reply_idx >= REPLY_BYTES) begin
                     reply_idx = 0;
                     reply_bits = '1;
                     clear_rx();
                  end else begin
                     reply_bits = {1'b1, info_byte(reply_idx), 1'b0};
                  end
               end
            end
         end
         PH_RECV: begin
            if (tick_cnt != 0) begin
               tick_cnt--;
               return;
            end
            if (lvl) rx_bits[bit_idx] = 1'b1;
            bit_idx++;
            if (bit_idx < 10) begin
               tick_cnt = per - 1;
               return;
            end
            bit_idx = 0;
            tick_cnt = 0;
            ph = PH_WAIT;
            if (rx_bits[0] || !rx_bits[9]) begin
               close_frame();
               return;
            end
            b = rx_bits[8:1];
            tick_res.byte_valid = 1'b1;
            tick_res.byte_value = b;
            if (byte_cnt >= 2) crc_acc = crc16_arc_step(crc_acc, older_byte);
            older_byte = newest_byte;
            newest_byte = b;
            byte_cnt++;
            if (byte_cnt >= FULL_FRAME) close_frame();
         end
         default: begin
            if (!lvl) begin
               rx_bits = 0;
               ph = PH_RECV;
               if (cfg.first_offset == 0) begin
                  bit_idx = 1;
                  tick_cnt = per - 1;
               end else begin
                  bit_idx = 0;
                  tick_cnt = {6'd0, cfg.first_offset} - 1;
               end
            end else begin
               tick_cnt++;
               lim = (cfg.wait_limit == 0) ? 16'd1 : cfg.wait_limit;
               if (tick_cnt >= lim) begin
                  tick_cnt = 0;
                  close_frame();
               end
            end
         end
      endcase
   endfunction

   task automatic report(string what, int got, int want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // Model update and result checking, all at the rising edge.
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BIT_PERIOD:   cfg.bit_period   = csr_data[9:0];
               CSR_FIRST_OFFSET: cfg.first_offset = csr_data[9:0];
               CSR_WAIT_LIMIT:   cfg.wait_limit   = csr_data[15:0];
               CSR_MARKER:       cfg.marker       = csr_data[7:0];
               CSR_INIT_LEN:     cfg.init_len     = csr_data[7:0];
               CSR_INFO_ZERO:    cfg.info_zero    = csr_data;
               CSR_INFO_ONE:     cfg.info_one     = csr_data;
               default:          cfg.info_last    = csr_data[7:0];
            endcase
         end
         if (req_valid && req_ready) begin
            line_tick(req_line_level);
            line_results.push_back(tick_res);
         end
         if (rsp_valid && rsp_ready) begin
            if (line_results.size() == 0) begin
               report("unexpected word", 1, 0);
            end else begin
               want = line_results.pop_front();
               if (rsp_line_out !== want.line_out)
                  report("line_out", rsp_line_out, want.line_out);
               if (rsp_line_drive !== want.line_drive)
                  report("line_drive", rsp_line_drive, want.line_drive);
               if (rsp_byte_valid !== want.byte_valid)
                  report("byte_valid", rsp_byte_valid, want.byte_valid);
               if (rsp_byte_value !== want.byte_value)
                  report("byte_value", rsp_byte_value, want.byte_value);
               if (rsp_frame_done !== want.frame_done)
                  report("frame_done", rsp_frame_done, want.frame_done);
               if (rsp_frame_length !== want.frame_length)
                  report("frame_length", rsp_frame_length, want.frame_length);
               if (rsp_frame_verdict !== want.frame_verdict)
                  report("frame_verdict", rsp_frame_verdict, want.frame_verdict);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("one_wire_uart_boot_frame_checker_unit_tb: errors");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_cnt = 400;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send_tick(logic lvl);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_line_level <= lvl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      ticks_sent++;
   endtask

   task automatic send_level(logic lvl, int n);
      repeat (n) send_tick(lvl);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(int per, int off, int lim);
      write_reg(CSR_BIT_PERIOD, per);
      write_reg(CSR_FIRST_OFFSET, off);
      write_reg(CSR_WAIT_LIMIT, lim);
   endtask

   function automatic int limit_ticks();
      return (cfg.wait_limit == 0) ? 1 : cfg.wait_limit;
   endfunction

   // One character on the line: a low edge tick, then each of the ten bits
   // held so that it covers its sample tick.
   task automatic send_char(logic [7:0] b, logic start_bit, logic stop_bit);
      int per;
      int off;
      int k;
      logic [9:0] bits;
      per = period_ticks();
      off = cfg.first_offset;
      bits = {stop_bit, b, start_bit};
      send_tick(1'b0);
      for (int t = 1; t <= off + 9 * per; t++) begin
         k = (t < off) ? 0 : (t - off) / per;
         if (k > 9) k = 9;
         send_tick(bits[k]);
      end
   endtask

   task automatic send_frame(logic [7:0] bytes[$], int gap_max);
      int g;
      foreach (bytes[i]) begin
         send_char(bytes[i], 1'b0, 1'b1);
         g = $urandom_range(0, gap_max);
         if (g >= limit_ticks()) g = limit_ticks() - 1;
         send_level(1'b1, g);
      end
   endtask

   // Ends the frame by timeout and waits out any reply.
   task automatic finish_frame();
      send_level(1'b1, limit_ticks() + 1);
      if (ph == PH_SEND) send_level(1'b1, REPLY_BYTES * 10 * period_ticks() + 2);
   endtask

   function automatic void add_crc(ref logic [7:0] bytes[$], input logic corrupt);
      logic [15:0] c;
      c = 0;
      foreach (bytes[i]) c = crc16_arc_step(c, bytes[i]);
      if (corrupt) c ^= 16'd1 << $urandom_range(15);
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
   endfunction

   function automatic void fill_random(ref logic [7:0] bytes[$], input int n);
      bytes.delete();
      repeat (n) bytes.push_back($urandom_range(255));
   endfunction

   task automatic test_register_extremes();
      logic [7:0] bytes[$];
      set_timing(8, 5, 65535);
      write_reg(CSR_MARKER, 0);
      write_reg(CSR_INIT_LEN, 248);
      write_reg(CSR_INFO_ZERO, 32'hFFFF_FFFF);
      write_reg(CSR_INFO_ONE, 32'h0000_0000);
      write_reg(CSR_INFO_LAST, 255);
      // A broken stop bit ends the frame, since the wait limit is too long.
      send_char(8'hA5, 1'b0, 1'b1);
      send_char(8'h5A, 1'b0, 1'b0);
      send_level(1'b1, 4);
   endtask

   task automatic test_zero_settings();
      set_timing(0, 0, 0);
      send_char(8'h00, 1'b0, 1'b1);
      send_char(8'hFF, 1'b0, 1'b1);
      finish_frame();
   endtask

   task automatic test_framing_errors();
      set_timing(2, 1, 10);
      send_char(8'h3C, 1'b1, 1'b1);   // bad start with no bytes: no frame
      send_char(8'h81, 1'b0, 1'b0);   // bad stop with no bytes
      send_char(8'h81, 1'b0, 1'b1);
      send_char(8'h7E, 1'b1, 1'b1);   // bad start ends a one-byte frame
      finish_frame();
   endtask

   task automatic test_crc_frames();
      logic [7:0] bytes[$];
      set_timing(1, 0, 6);
      fill_random(bytes, 4);
      add_crc(bytes, 1'b0);
      send_frame(bytes, 3);
      finish_frame();
      fill_random(bytes, 5);
      add_crc(bytes, 1'b1);
      send_frame(bytes, 3);
      finish_frame();
      fill_random(bytes, 1);
      add_crc(bytes, 1'b0);
      send_frame(bytes, 0);
      finish_frame();
      fill_random(bytes, 2);
      send_frame(bytes, 0);
      finish_frame();
   endtask

   task automatic test_init_reply();
      logic [7:0] bytes[$];
      set_timing(1, 1, 8);
      write_reg(CSR_INFO_ZERO, $urandom);
      write_reg(CSR_INFO_ONE, $urandom);
      write_reg(CSR_INFO_LAST, $urandom_range(255));
      write_reg(CSR_MARKER, 8'h7D);
      write_reg(CSR_INIT_LEN, 21);
      fill_random(bytes, 20);
      bytes.push_back(8'h7D);
      send_frame(bytes, 2);
      send_level(1'b1, limit_ticks());
      // The line is ignored during the reply, so drive noise into it.
      repeat (REPLY_BYTES * 10 + 2) send_tick($urandom_range(1));
      send_level(1'b1, limit_ticks() + 1);
      // Marker with the wrong length goes to the CRC check.
      fill_random(bytes, 3);
      bytes.push_back(8'h7D);
      send_frame(bytes, 0);
      finish_frame();
      write_reg(CSR_INIT_LEN, 1);
      bytes.delete();
      bytes.push_back(8'h7D);
      send_frame(bytes, 0);
      finish_frame();
   endtask

   task automatic test_backpressure();
      logic [7:0] bytes[$];
      set_timing(1, 1, 5);
      hold_seq++;
      fill_random(bytes, 4);
      add_crc(bytes, 1'b0);
      send_frame(bytes, 2);
      finish_frame();
      // Let everything drain before the sender goes on.
      wait_drained();
      fill_random(bytes, 3);
      add_crc(bytes, 1'b0);
      send_frame(bytes, 2);
      finish_frame();
   endtask

   task automatic test_random(int s_idle, int r_stall, int ticks);
      logic [7:0] bytes[$];
      int per;
      int first;
      int kind;
      int n;
      per = $urandom_range(0, 3);
      set_timing(per, $urandom_range(0, per + 1), $urandom_range(3, 25));
      write_reg(CSR_MARKER, $urandom_range(255));
      write_reg(CSR_INIT_LEN, $urandom_range(1, 6));
      write_reg(CSR_INFO_ZERO, $urandom);
      send_idle = s_idle;
      recv_stall = r_stall;
      first = ticks_sent;
      while (ticks_sent - first < ticks) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            fill_random(bytes, $urandom_range(1, 6));
            add_crc(bytes, 1'b0);
            send_frame(bytes, 3);
         end else if (kind < 72) begin
            fill_random(bytes, cfg.init_len - 1);
            bytes.push_back(cfg.marker);
            send_frame(bytes, 3);
         end else if (kind < 82) begin
            fill_random(bytes, $urandom_range(1, 6));
            add_crc(bytes, 1'b1);
            send_frame(bytes, 3);
         end else if (kind < 90) begin
            n = $urandom_range(1, 4);
            fill_random(bytes, n);
            send_frame(bytes, 1);
            send_char($urandom_range(255), $urandom_range(1), $urandom_range(1));
         end else begin
            repeat ($urandom_range(1, 30)) send_tick($urandom_range(1));
            send_level(1'b1, cfg.first_offset + 10 * period_ticks() + 2);
         end
         finish_frame();
      end
      send_idle = 0;
      recv_stall = 0;
   endtask

   initial begin
      cfg.bit_period = 52;
      cfg.first_offset = 6;
      cfg.wait_limit = 2000;
      cfg.marker = 125;
      cfg.init_len = 21;
      cfg.info_zero = 3225396;
      cfg.info_one = 17171999;
      cfg.info_last = 48;
      clear_rx();
      rx_bits = 0;
      reply_idx = 0;
      reply_bits = '1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_extremes();
      test_zero_settings();
      test_framing_errors();
      test_crc_frames();
      test_init_reply();
      test_backpressure();
      test_random(0, 0, 40);
      test_random(70, 0, 40);
      test_random(0, 70, 40);
      test_random(18, 18, 40);
      test_random(0, 0, 40);

      req_valid <= 1'b0;
      @(posedge clock);
      while (line_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("one_wire_uart_boot_frame_checker_unit_tb: clean");
      else
         $display("one_wire_uart_boot_frame_checker_unit_tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/owubfc_pkg.sv
rtl/core/owubfc_front.sv
rtl/core/owubfc_engine.sv
rtl/core/one_wire_uart_boot_frame_checker_unit.sv
rtl/core/owubfc_checker.sv
sim/one_wire_uart_boot_frame_checker_unit_tb.sv
